FILE: rtl/core/polarize_acquire_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polarize/acquire sequencer
// Clocked property wrappers used by the checker file pas_checker.
// ----------------------------------------------------------------------------
`ifndef POLARIZE_ACQUIRE_SEQUENCER_MACROS_SVH
`define POLARIZE_ACQUIRE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

FILE: rtl/core/pas_pkg.sv
// ----------------------------------------------------------------------------
// pas_pkg
// Types and codes for the polarize/acquire sequencer.
// ----------------------------------------------------------------------------
package pas_pkg;

    // command codes
    localparam logic [1:0] CMD_START     = 2'd0;
    localparam logic [1:0] CMD_POL_TICK  = 2'd1;
    localparam logic [1:0] CMD_ACQ_TICK  = 2'd2;

    // event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_WAIT   = 3'd1;
    localparam logic [2:0] EV_BEGIN  = 3'd2;
    localparam logic [2:0] EV_SAMPLE = 3'd3;
    localparam logic [2:0] EV_DONE   = 3'd4;

    // phase codes as reported on the result
    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_POL  = 2'd1;
    localparam logic [1:0] PHASE_SAMP = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_POLARIZE_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SETPOINT = 2'd2;

    // register reset values
    localparam logic [15:0] RST_POLARIZE_TICKS   = 16'd62;
    localparam logic [31:0] RST_SAMPLE_COUNT     = 32'd16384;
    localparam logic [11:0] RST_CURRENT_SETPOINT = 12'd256;

    typedef struct packed {
        logic [15:0] polarize_ticks;
        logic [31:0] sample_count;
        logic [11:0] current_setpoint;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] adc_sample;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_code;
        logic [15:0] sample_value;
        logic [11:0] dac_drive;
        logic        sink_enable;
        logic        relay_to_amplifier;
        logic [1:0]  phase_now;
    } t_out_item;

endpackage

FILE: rtl/core/polarize_acquire_sequencer.sv
// ----------------------------------------------------------------------------
// polarize_acquire_sequencer
// Runs one polarize-then-acquire magnetometer experiment per start command.
// ----------------------------------------------------------------------------
// Every command transaction yields exactly one result transaction, in the cycle
// after acceptance. A new command can be taken on every cycle in which the
// single result register is empty or is being read in that same cycle; while
// a result waits with the receiver not ready, the command input stalls until
// it is read. Throughput is one transaction per clock while results are read
// as they arrive, set by that result register. Configuration writes are
// registered, take effect on the next comparison, and should be made while no
// transaction is in flight. The DAC value is latched from current_setpoint at
// start and held until switchover.
module polarize_acquire_sequencer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  pas_pkg::t_in_item                     i_in_item,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output pas_pkg::t_out_item                    o_out_item,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [pas_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pas_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    pas_pkg::t_cfg      r_cfg;
    pas_pkg::t_out_item r_out_item;
    pas_pkg::t_out_item step_result;
    logic               r_out_valid, n_out_valid;
    logic               accept;

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polarize_ticks   <= pas_pkg::RST_POLARIZE_TICKS;
            r_cfg.sample_count     <= pas_pkg::RST_SAMPLE_COUNT;
            r_cfg.current_setpoint <= pas_pkg::RST_CURRENT_SETPOINT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pas_pkg::REG_POLARIZE_TICKS:   r_cfg.polarize_ticks   <= i_cfg_data[15:0];
                pas_pkg::REG_SAMPLE_COUNT:     r_cfg.sample_count     <= i_cfg_data[31:0];
                pas_pkg::REG_CURRENT_SETPOINT: r_cfg.current_setpoint <= i_cfg_data[11:0];
                default: ; // unmapped index: write dropped
            endcase
        end
    end

    // ---- handshake: accept when the result slot is empty or draining ----
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // ---- sequencer core: state advances only on an accepted transaction ----
    pas_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    // ---- result register ----
    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/core/pas_step.sv
// ----------------------------------------------------------------------------
// pas_step
// Experiment state machine: phase, tick counters, relay, sink and DAC state.
// ----------------------------------------------------------------------------
module pas_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  pas_pkg::t_in_item   i_item,
    input  pas_pkg::t_cfg       i_cfg,
    output pas_pkg::t_out_item  o_result
);

    typedef enum logic [1:0] {
        S_IDLE = pas_pkg::PHASE_IDLE,
        S_POL  = pas_pkg::PHASE_POL,
        S_SAMP = pas_pkg::PHASE_SAMP
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [16:0] r_pol_cnt,  n_pol_cnt;
    logic [32:0] r_samp_cnt, n_samp_cnt;
    logic        r_relay,    n_relay;
    logic        r_sink,     n_sink;
    logic [11:0] r_dac,      n_dac;
    logic [2:0]  ev;
    logic [15:0] sval;
    logic [16:0] pol_inc;
    logic [32:0] samp_inc;

    assign pol_inc  = r_pol_cnt + 17'd1;
    assign samp_inc = r_samp_cnt + 33'd1;

    always_comb begin
        n_phase    = r_phase;
        n_pol_cnt  = r_pol_cnt;
        n_samp_cnt = r_samp_cnt;
        n_relay    = r_relay;
        n_sink     = r_sink;
        n_dac      = r_dac;
        ev         = pas_pkg::EV_NONE;
        sval       = '0;
        case (r_phase)
            S_IDLE: begin
                if (i_item.command == pas_pkg::CMD_START) begin
                    n_pol_cnt  = '0;
                    n_samp_cnt = '0;
                    if (i_cfg.current_setpoint != 12'd0) begin
                        n_relay = 1'b0;
                        n_sink  = 1'b1;
                        n_dac   = i_cfg.current_setpoint;
                        n_phase = S_POL;
                    end else begin
                        // no coil current: straight to acquisition
                        ev      = pas_pkg::EV_BEGIN;
                        n_phase = S_SAMP;
                    end
                end
            end
            S_POL: begin
                if (i_item.command == pas_pkg::CMD_POL_TICK) begin
                    if (pol_inc > {1'b0, i_cfg.polarize_ticks}) begin
                        n_pol_cnt = '0;
                        n_dac     = '0;
                        n_sink    = 1'b0;
                        n_relay   = 1'b1;
                        ev        = pas_pkg::EV_BEGIN;
                        n_phase   = S_SAMP;
                    end else begin
                        n_pol_cnt = pol_inc;
                        ev        = pas_pkg::EV_WAIT;
                    end
                end
            end
            S_SAMP: begin
                if (i_item.command == pas_pkg::CMD_ACQ_TICK) begin
                    if (samp_inc > {1'b0, i_cfg.sample_count}) begin
                        n_samp_cnt = '0;
                        ev         = pas_pkg::EV_DONE;
                        n_phase    = S_IDLE;
                    end else begin
                        n_samp_cnt = samp_inc;
                        ev         = pas_pkg::EV_SAMPLE;
                        sval       = i_item.adc_sample;
                    end
                end
            end
            default: begin
                n_phase = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= S_IDLE;
            r_pol_cnt  <= '0;
            r_samp_cnt <= '0;
            r_relay    <= 1'b0;
            r_sink     <= 1'b0;
            r_dac      <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_pol_cnt  <= n_pol_cnt;
            r_samp_cnt <= n_samp_cnt;
            r_relay    <= n_relay;
            r_sink     <= n_sink;
            r_dac      <= n_dac;
        end
    end

    // result reflects the state after this step
    assign o_result.event_code         = ev;
    assign o_result.sample_value       = sval;
    assign o_result.dac_drive          = n_dac;
    assign o_result.sink_enable        = n_sink;
    assign o_result.relay_to_amplifier = n_relay;
    assign o_result.phase_now          = n_phase;

endmodule

FILE: rtl/core/pas_checker.sv
// ----------------------------------------------------------------------------
// pas_checker
// Port-level checks for the polarize/acquire sequencer, bound to the top.
// ----------------------------------------------------------------------------
`include "polarize_acquire_sequencer_macros.svh"

module pas_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  pas_pkg::t_out_item i_out_item
);

    // stalled result holds
    `PAS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_item))

    // sink is on exactly while polarizing
    `PAS_ASSERT_NOW(a_sink_phase, i_clk, i_rst_n, i_out_valid, i_out_item.sink_enable == (i_out_item.phase_now == pas_pkg::PHASE_POL))

    // converter word only passes with a sample event
    `PAS_ASSERT_NOW(a_sample_zero, i_clk, i_rst_n, i_out_valid && (i_out_item.event_code != pas_pkg::EV_SAMPLE), i_out_item.sample_value == 16'd0)

    // begin and sample events leave the block sampling
    `PAS_ASSERT_NOW(a_evt_phase, i_clk, i_rst_n, i_out_valid && ((i_out_item.event_code == pas_pkg::EV_SAMPLE) || (i_out_item.event_code == pas_pkg::EV_BEGIN)), i_out_item.phase_now == pas_pkg::PHASE_SAMP)

endmodule

bind polarize_acquire_sequencer pas_checker u_pas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

FILE: verif/polarize_acquire_sequencer_tb.sv
// ----------------------------------------------------------------------------
// polarize_acquire_sequencer_tb
// Self-checking bench: drives command transactions with random gaps and
// back-pressure, predicts every result transaction in a local model of the
// experiment sequencer and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module polarize_acquire_sequencer_tb;
    import pas_pkg::*;

    // command code with no meaning in any phase
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned REPORT_MAX = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // register copies, updated when a write lands
    logic [15:0] cfg_polarize_ticks;
    logic [31:0] cfg_sample_count;
    logic [11:0] cfg_current_setpoint;

    // sequencer state as predicted
    logic [1:0]  seq_phase;
    logic [16:0] pol_ticks_seen;
    logic [32:0] samples_seen;
    logic        relay_amp;
    logic        sink_on;
    logic [11:0] dac_level;

    t_out_item   expected_events[$];
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned cycle_count;

    // idle percentages for each side, changed per test phase
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // long receiver hold-off: requested by a test, counted down by the receiver
    int unsigned stall_request;
    int unsigned stall_left;

    polarize_acquire_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Experiment model: one command in, one report out
    // ------------------------------------------------------------------
    function automatic t_out_item advance_sequencer(input t_in_item cmd_item);
        t_out_item rpt;
        rpt = '0;
        rpt.event_code = EV_NONE;
        if (cmd_item.command == CMD_START && seq_phase == PHASE_IDLE) begin
            pol_ticks_seen = '0;
            samples_seen = '0;
            if (cfg_current_setpoint != '0) begin
                relay_amp = 1'b0;
                sink_on = 1'b1;
                dac_level = cfg_current_setpoint;
                seq_phase = PHASE_POL;
            end else begin
                // no polarization: relay, sink and DAC stay as they are
                rpt.event_code = EV_BEGIN;
                seq_phase = PHASE_SAMP;
            end
        end else if (cmd_item.command == CMD_POL_TICK && seq_phase == PHASE_POL) begin
            pol_ticks_seen = pol_ticks_seen + 17'd1;
            if (pol_ticks_seen > {1'b0, cfg_polarize_ticks}) begin
                // switchover to acquisition
                pol_ticks_seen = '0;
                dac_level = '0;
                sink_on = 1'b0;
                relay_amp = 1'b1;
                rpt.event_code = EV_BEGIN;
                seq_phase = PHASE_SAMP;
            end else begin
                rpt.event_code = EV_WAIT;
            end
        end else if (cmd_item.command == CMD_ACQ_TICK && seq_phase == PHASE_SAMP) begin
            samples_seen = samples_seen + 33'd1;
            if (samples_seen > {1'b0, cfg_sample_count}) begin
                samples_seen = '0;
                rpt.event_code = EV_DONE;
                seq_phase = PHASE_IDLE;
            end else begin
                rpt.event_code = EV_SAMPLE;
                rpt.sample_value = cmd_item.adc_sample;
            end
        end
        rpt.dac_drive = dac_level;
        rpt.sink_enable = sink_on;
        rpt.relay_to_amplifier = relay_amp;
        rpt.phase_now = seq_phase;
        return rpt;
    endfunction

    // every accepted command transaction yields one expected report
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            expected_events.push_back(advance_sequencer(in_item));
    end

    // result checker
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_events.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("cycle %0d: result transaction with nothing expected", cycle_count);
                mismatches++;
            end else begin
                want = expected_events.pop_front();
                if (out_item.event_code !== want.event_code
                        || out_item.sample_value !== want.sample_value
                        || out_item.dac_drive !== want.dac_drive
                        || out_item.sink_enable !== want.sink_enable
                        || out_item.relay_to_amplifier !== want.relay_to_amplifier
                        || out_item.phase_now !== want.phase_now) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("cycle %0d: exp ev=%0d smp=%h dac=%h sink=%b relay=%b ph=%0d",
                                 cycle_count, want.event_code, want.sample_value,
                                 want.dac_drive, want.sink_enable,
                                 want.relay_to_amplifier, want.phase_now);
                        $display("          got ev=%0d smp=%h dac=%h sink=%b relay=%b ph=%0d",
                                 out_item.event_code, out_item.sample_value,
                                 out_item.dac_drive, out_item.sink_enable,
                                 out_item.relay_to_amplifier, out_item.phase_now);
                    end
                    mismatches++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (stall_request != 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[polarize_acquire_sequencer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // one command transaction; valid stays high on return so back-to-back
    // commands need no gap
    task automatic send_command(input logic [1:0] cmd, input logic [15:0] adc);
        t_in_item nxt;
        nxt.command = cmd;
        nxt.adc_sample = adc;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= nxt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // stop offering and wait until every report is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_events.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POLARIZE_TICKS:   cfg_polarize_ticks = data[15:0];
            REG_SAMPLE_COUNT:     cfg_sample_count = data;
            REG_CURRENT_SETPOINT: cfg_current_setpoint = data[11:0];
            default: ;
        endcase
    endtask

    // a command that does nothing in the given phase
    function automatic logic [1:0] misfit_command(input logic [1:0] ph);
        logic [1:0] c;
        do begin
            c = 2'($urandom_range(3));
        end while ((c == CMD_START && ph == PHASE_IDLE)
                   || (c == CMD_POL_TICK && ph == PHASE_POL)
                   || (c == CMD_ACQ_TICK && ph == PHASE_SAMP));
        return c;
    endfunction

    task automatic maybe_noise(input logic [1:0] ph, input int unsigned pct);
        if ($urandom_range(99) < pct)
            send_command(misfit_command(ph), 16'($urandom));
    endtask

    // full experiment for the current register values, sprinkled with
    // commands that do not fit the phase
    task automatic run_experiment(input int unsigned noise_pct);
        int unsigned n;
        maybe_noise(PHASE_IDLE, noise_pct);
        send_command(CMD_START, 16'($urandom));
        if (cfg_current_setpoint != '0) begin
            for (n = 0; n <= cfg_polarize_ticks; n++) begin
                maybe_noise(PHASE_POL, noise_pct);
                send_command(CMD_POL_TICK, 16'($urandom));
            end
        end
        for (n = 0; n <= cfg_sample_count; n++) begin
            maybe_noise(PHASE_SAMP, noise_pct);
            send_command(CMD_ACQ_TICK, 16'($urandom));
        end
    endtask

    // small counts keep experiments short; set-point extremes are common
    task automatic shuffle_registers();
        int unsigned pick;
        if ($urandom_range(1) == 0) begin
            pick = $urandom_range(99);
            write_reg(REG_POLARIZE_TICKS, (pick < 85) ? $urandom_range(6) : $urandom_range(7, 40));
        end
        if ($urandom_range(1) == 0) begin
            pick = $urandom_range(99);
            write_reg(REG_SAMPLE_COUNT, (pick < 85) ? $urandom_range(10) : $urandom_range(11, 60));
        end
        if ($urandom_range(1) == 0) begin
            pick = $urandom_range(99);
            if (pick < 20)
                write_reg(REG_CURRENT_SETPOINT, 0);
            else if (pick < 30)
                write_reg(REG_CURRENT_SETPOINT, 4095);
            else
                write_reg(REG_CURRENT_SETPOINT, $urandom_range(1, 4095));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset register values, misfit commands in every phase, and register
    // writes in the middle of an experiment
    task automatic test_reset_defaults();
        send_command(CMD_POL_TICK, 16'h1234);
        send_command(CMD_ACQ_TICK, 16'hFFFF);
        send_command(CMD_UNUSED, 16'hFFFF);
        send_command(CMD_START, 16'h0000);          // set-point 256 from reset
        send_command(CMD_START, 16'hA5A5);
        send_command(CMD_ACQ_TICK, 16'h5A5A);
        send_command(CMD_UNUSED, 16'h0000);
        send_command(CMD_POL_TICK, 16'h0000);
        send_command(CMD_POL_TICK, 16'h0000);
        write_reg(REG_POLARIZE_TICKS, 1);           // next tick passes the count
        send_command(CMD_POL_TICK, 16'h0000);
        send_command(CMD_START, 16'hFFFF);
        send_command(CMD_POL_TICK, 16'hFFFF);
        send_command(CMD_UNUSED, 16'hFFFF);
        send_command(CMD_ACQ_TICK, 16'h0000);
        send_command(CMD_ACQ_TICK, 16'hFFFF);
        write_reg(REG_SAMPLE_COUNT, 0);
        send_command(CMD_ACQ_TICK, 16'h8001);
    endtask

    // zero set-point skips polarization and leaves the relay on the amplifier;
    // zero tick and sample counts switch over on the first tick
    task automatic test_zero_setpoint();
        write_reg(REG_CURRENT_SETPOINT, 0);
        send_command(CMD_START, 16'h0000);
        send_command(CMD_ACQ_TICK, 16'hFFFF);
        write_reg(REG_CURRENT_SETPOINT, 4095);
        write_reg(REG_POLARIZE_TICKS, 0);
        send_command(CMD_START, 16'hFFFF);
        send_command(CMD_POL_TICK, 16'h0000);
        send_command(CMD_ACQ_TICK, 16'h7FFF);
    endtask

    // largest tick and sample counts, cut short by later writes
    task automatic test_register_extremes();
        write_reg(REG_POLARIZE_TICKS, 65535);
        write_reg(REG_SAMPLE_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_CURRENT_SETPOINT, 1);
        send_command(CMD_START, 16'h0001);
        send_command(CMD_POL_TICK, 16'h0001);
        write_reg(REG_POLARIZE_TICKS, 0);
        send_command(CMD_POL_TICK, 16'h0001);
        send_command(CMD_ACQ_TICK, 16'hFFFE);
        write_reg(REG_SAMPLE_COUNT, 0);
        send_command(CMD_ACQ_TICK, 16'h0001);
    endtask

    // receiver holds off for a long stretch while commands keep coming
    task automatic test_backpressure();
        write_reg(REG_POLARIZE_TICKS, 3);
        write_reg(REG_SAMPLE_COUNT, 12);
        write_reg(REG_CURRENT_SETPOINT, 2048);
        stall_request = 250;
        run_experiment(0);
    endtask

    // mostly well-formed experiments, some random bursts of any command
    task automatic test_random_experiments(input int unsigned n_items);
        int unsigned stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 6))
                    send_command(2'($urandom_range(3)), 16'($urandom));
            end else begin
                if ($urandom_range(99) < 40)
                    shuffle_registers();
                run_experiment(12);
            end
        end
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cfg_polarize_ticks = RST_POLARIZE_TICKS;
        cfg_sample_count = RST_SAMPLE_COUNT;
        cfg_current_setpoint = RST_CURRENT_SETPOINT;
        seq_phase = PHASE_IDLE;
        pol_ticks_seen = '0;
        samples_seen = '0;
        relay_amp = 1'b0;
        sink_on = 1'b0;
        dac_level = '0;
        mismatches = 0;
        items_sent = 0;
        cycle_count = 0;
        stall_request = 0;
        stall_left = 0;
        send_idle_pct = 36;
        recv_idle_pct = 69;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_setpoint();
        test_register_extremes();
        test_random_experiments(430);

        send_idle_pct = 69;
        recv_idle_pct = 36;
        test_random_experiments(430);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_experiments(430);

        // a short pause catches stray results
        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_events.size() == 0)
            $display("[polarize_acquire_sequencer] OK");
        else
            $display("[polarize_acquire_sequencer] ERROR");
        $finish;
    end

endmodule
